// File: design/initiative_exchange_sorter_top_defines.svh
// Assertion macros for the initiative exchange sorter checker.
// Included by design/ies_checker.sv; needs no other file.
`ifndef INITIATIVE_EXCHANGE_SORTER_TOP_DEFINES_SVH
`define INITIATIVE_EXCHANGE_SORTER_TOP_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define IES_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ies check failed");

// next-cycle implication, held off while reset is low
`define IES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ies check failed");

`endif

// File: design/ies_pkg.sv
// Shared types, state encoding and key helpers for the initiative exchange sorter.
// No dependencies; used by ies_ctrl, ies_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ies_pkg;

    typedef struct packed {
        logic [7:0]  roll;
        logic [7:0]  modifier;
        logic [15:0] hit_points;
        logic [7:0]  tag;
    } record_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_J_RD,
        ST_J_LD,
        ST_I_RD,
        ST_I_CMP,
        ST_J_WB,
        ST_E_RD,
        ST_E_LD,
        ST_E_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_count;
        logic pos_clr;
        logic pos_inc;
        logic i_set;
        logic i_inc;
        logic rd_use_i;
        logic cur_load;
        logic cmp_en;
        logic wb_pos;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic j_done;
        logic i_last;
        logic pos_last;
    } status_t;

    function automatic logic signed [9:0] rec_total(record_t r);
        logic signed [9:0] roll_ext;
        logic signed [9:0] mod_ext;
        roll_ext = $signed({2'b00, r.roll});
        mod_ext  = $signed({{2{r.modifier[7]}}, r.modifier});
        return roll_ext + mod_ext;
    endfunction

    function automatic logic rec_better(record_t a, record_t b);
        logic signed [9:0] ta;
        logic signed [9:0] tb;
        ta = rec_total(a);
        tb = rec_total(b);
        return (ta > tb) || ((ta == tb) && (a.roll > b.roll));
    endfunction

endpackage

`default_nettype wire

// File: design/initiative_exchange_sorter_top.sv
// Initiative exchange sorter: collects records, exchange-sorts them by roll plus modifier.
// Top level; depends on ies_pkg, ies_ctrl and ies_datapath.
//
// Usage:
//   Input channel s_*: one record per transfer (roll, modifier, hit points, tag,
//   final_item). Records beyond CAPACITY are dropped; a final item still closes the set.
//   Loading accepts a record on every clock; s_ready is high only while collecting.
//   On the final transfer the block sorts the n held records in place in its
//   record memory (one read port, one write port): for each outer position it
//   holds that record, exchanges it with each later record that ranks higher,
//   and writes the held record back. Result channel m_*: the n records in sorted
//   order with their total, the last one flagged by m_end_of_run. Each result
//   passes through a memory read and an output register load before m_valid is
//   raised, and holds while m_ready is low; input is refused until the last result
//   transfers, after which a new, empty set begins.
//   Reset (aresetn low, synchronous) empties the set and returns to collecting.
`timescale 1ns / 1ps
`default_nettype none

module initiative_exchange_sorter_top #(
    parameter int CAPACITY = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_roll,
    input  wire logic signed [7:0]  s_modifier,
    input  wire logic signed [15:0] s_hit_points,
    input  wire logic [7:0]         s_tag,
    input  wire logic               s_final_item,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_out_roll,
    output logic signed [7:0]       m_out_modifier,
    output logic signed [15:0]      m_out_hit_points,
    output logic [7:0]              m_out_tag,
    output logic signed [9:0]       m_total,
    output logic                    m_end_of_run
);

    ies_pkg::cmd_t    cmd;
    ies_pkg::status_t status;

    ies_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_final_item (s_final_item),
        .s_ready      (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .status       (status),
        .cmd          (cmd)
    );

    ies_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_roll           (s_roll),
        .s_modifier       (s_modifier),
        .s_hit_points     (s_hit_points),
        .s_tag            (s_tag),
        .m_out_roll       (m_out_roll),
        .m_out_modifier   (m_out_modifier),
        .m_out_hit_points (m_out_hit_points),
        .m_out_tag        (m_out_tag),
        .m_total          (m_total),
        .m_end_of_run     (m_end_of_run)
    );

endmodule

`default_nettype wire

// File: design/ies_ctrl.sv
// Controller for the initiative exchange sorter: load, sort and emit sequencing.
// Depends on ies_pkg; drives ies_datapath through cmd_t and reads status_t.
`timescale 1ns / 1ps
`default_nettype none

module ies_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_final_item,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  ies_pkg::status_t      status,
    output ies_pkg::cmd_t         cmd
);

    ies_pkg::state_t state_reg;
    ies_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ies_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ies_pkg::ST_IDLE: begin
                if (s_valid && s_final_item) begin
                    state_next = ies_pkg::ST_J_RD;
                end
            end
            ies_pkg::ST_J_RD: begin
                state_next = status.j_done ? ies_pkg::ST_E_RD : ies_pkg::ST_J_LD;
            end
            ies_pkg::ST_J_LD:  state_next = ies_pkg::ST_I_RD;
            ies_pkg::ST_I_RD:  state_next = ies_pkg::ST_I_CMP;
            ies_pkg::ST_I_CMP: begin
                state_next = status.i_last ? ies_pkg::ST_J_WB : ies_pkg::ST_I_RD;
            end
            ies_pkg::ST_J_WB:  state_next = ies_pkg::ST_J_RD;
            ies_pkg::ST_E_RD:  state_next = ies_pkg::ST_E_LD;
            ies_pkg::ST_E_LD:  state_next = ies_pkg::ST_E_OUT;
            ies_pkg::ST_E_OUT: begin
                if (m_ready) begin
                    state_next = status.pos_last ? ies_pkg::ST_IDLE : ies_pkg::ST_E_RD;
                end
            end
            default: state_next = ies_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ies_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load    = s_valid;
                cmd.pos_clr = s_valid && s_final_item;
            end
            ies_pkg::ST_J_RD: begin
                cmd.pos_clr = status.j_done;
            end
            ies_pkg::ST_J_LD: begin
                cmd.cur_load = 1'b1;
                cmd.i_set    = 1'b1;
            end
            ies_pkg::ST_I_RD: begin
                cmd.rd_use_i = 1'b1;
            end
            ies_pkg::ST_I_CMP: begin
                cmd.cmp_en = 1'b1;
                cmd.i_inc  = !status.i_last;
            end
            ies_pkg::ST_J_WB: begin
                cmd.wb_pos  = 1'b1;
                cmd.pos_inc = 1'b1;
            end
            ies_pkg::ST_E_RD: begin
            end
            ies_pkg::ST_E_LD: begin
                cmd.out_load = 1'b1;
            end
            ies_pkg::ST_E_OUT: begin
                m_valid       = 1'b1;
                cmd.pos_inc   = m_ready && !status.pos_last;
                cmd.clr_count = m_ready && status.pos_last;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/ies_datapath.sv
// Datapath for the initiative exchange sorter: record memory, counters, compare, output register.
// Depends on ies_pkg; commanded by ies_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module ies_datapath #(
    parameter int CAPACITY = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  ies_pkg::cmd_t           cmd,
    output ies_pkg::status_t        status,
    input  wire logic [7:0]         s_roll,
    input  wire logic signed [7:0]  s_modifier,
    input  wire logic signed [15:0] s_hit_points,
    input  wire logic [7:0]         s_tag,
    output logic [7:0]              m_out_roll,
    output logic signed [7:0]       m_out_modifier,
    output logic signed [15:0]      m_out_hit_points,
    output logic [7:0]              m_out_tag,
    output logic signed [9:0]       m_total,
    output logic                    m_end_of_run
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    ies_pkg::record_t mem [CAPACITY];

    ies_pkg::record_t rdata_reg;
    ies_pkg::record_t cur_reg;
    ies_pkg::record_t out_reg;
    logic signed [9:0] total_reg;
    logic              last_reg;

    logic [CW-1:0] count_reg;
    logic [IW-1:0] pos_reg;
    logic [IW-1:0] i_reg;

    logic              full;
    logic              swap;
    logic              we;
    logic [IW-1:0]     waddr;
    ies_pkg::record_t  wdata;
    ies_pkg::record_t  in_rec;
    logic [IW-1:0]     raddr;

    assign in_rec = '{roll: s_roll, modifier: s_modifier,
                      hit_points: s_hit_points, tag: s_tag};
    assign full   = (count_reg == CW'(CAPACITY));
    assign swap   = ies_pkg::rec_better(rdata_reg, cur_reg);
    assign raddr  = cmd.rd_use_i ? i_reg : pos_reg;

    assign status.j_done   = ((CW'(pos_reg) + CW'(1)) >= count_reg);
    assign status.i_last   = ((CW'(i_reg) + CW'(1)) == count_reg);
    assign status.pos_last = ((CW'(pos_reg) + CW'(1)) == count_reg);

    always_comb begin
        we    = 1'b0;
        waddr = pos_reg;
        wdata = cur_reg;
        if (cmd.load && !full) begin
            we    = 1'b1;
            waddr = count_reg[IW-1:0];
            wdata = in_rec;
        end else if (cmd.cmp_en && swap) begin
            we    = 1'b1;
            waddr = i_reg;
        end else if (cmd.wb_pos) begin
            we    = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pos_reg   <= '0;
            i_reg     <= '0;
        end else begin
            if (cmd.clr_count) begin
                count_reg <= '0;
            end else if (cmd.load && !full) begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.pos_clr) begin
                pos_reg <= '0;
            end else if (cmd.pos_inc) begin
                pos_reg <= pos_reg + IW'(1);
            end
            if (cmd.i_set) begin
                i_reg <= pos_reg + IW'(1);
            end else if (cmd.i_inc) begin
                i_reg <= i_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cur_load) begin
            cur_reg <= rdata_reg;
        end else if (cmd.cmp_en && swap) begin
            cur_reg <= rdata_reg;
        end
        if (cmd.out_load) begin
            out_reg   <= rdata_reg;
            total_reg <= ies_pkg::rec_total(rdata_reg);
            last_reg  <= status.pos_last;
        end
    end

    assign m_out_roll       = out_reg.roll;
    assign m_out_modifier   = $signed(out_reg.modifier);
    assign m_out_hit_points = $signed(out_reg.hit_points);
    assign m_out_tag        = out_reg.tag;
    assign m_total          = total_reg;
    assign m_end_of_run     = last_reg;

endmodule

`default_nettype wire

// File: design/ies_checker.sv
// Port-level checks for the initiative exchange sorter, bound to the top level.
// Depends on initiative_exchange_sorter_top_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "initiative_exchange_sorter_top_defines.svh"

module ies_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               s_final_item,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [7:0]         m_out_roll,
    input wire logic signed [7:0]  m_out_modifier,
    input wire logic signed [9:0]  m_total,
    input wire logic               m_end_of_run
);

    `IES_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_total) && $stable(m_end_of_run))
    `IES_ASSERT_IMPLY(a_total_match, aclk, aresetn, m_valid, m_total == ($signed({2'b00, m_out_roll}) + $signed({{2{m_out_modifier[7]}}, m_out_modifier})))
    `IES_ASSERT_IMPLY(a_no_load_emit, aclk, aresetn, m_valid, !s_ready)
    `IES_ASSERT_NEXT(a_plain_no_out, aclk, aresetn, s_valid && s_ready && !s_final_item, !m_valid)

endmodule

bind initiative_exchange_sorter_top ies_checker u_ies_checker (.*);

`default_nettype wire

// File: verif/initiative_exchange_sorter_top_test.sv
// Self-checking testbench for initiative_exchange_sorter_top: random record sets, exchange-sort
// prediction in a small class, valid/ready stalls on both channels. Depends on ies_pkg and the top level.
`timescale 1ns / 1ps

module initiative_exchange_sorter_top_test;

    localparam int STORE_DEPTH  = 64;
    localparam int TARGET_ITEMS = 360;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;

    class initiative_order_predictor;
        ies_pkg::record_t held[STORE_DEPTH];
        int unsigned      held_count;
        ies_pkg::record_t sorted_q[$];
        bit               last_q[$];
        int unsigned      errors;

        function new();
            held_count = 0;
            errors     = 0;
        endfunction

        function int initiative_sum(ies_pkg::record_t r);
            return int'(r.roll) + int'($signed(r.modifier));
        endfunction

        function bit outranks(ies_pkg::record_t a, ies_pkg::record_t b);
            int sa;
            int sb;
            sa = initiative_sum(a);
            sb = initiative_sum(b);
            return (sa > sb) || ((sa == sb) && (a.roll > b.roll));
        endfunction

        // store the record if there is room; a final transfer sorts and releases the set
        function void take_record(ies_pkg::record_t r, bit last);
            ies_pkg::record_t swap;
            if (held_count < STORE_DEPTH) begin
                held[held_count] = r;
                held_count++;
            end
            if (last) begin
                for (int j = 0; j < held_count; j++) begin
                    for (int i = j + 1; i < held_count; i++) begin
                        if (outranks(held[i], held[j])) begin
                            swap    = held[i];
                            held[i] = held[j];
                            held[j] = swap;
                        end
                    end
                end
                for (int k = 0; k < held_count; k++) begin
                    sorted_q.push_back(held[k]);
                    last_q.push_back(k == held_count - 1);
                end
                held_count = 0;
            end
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void match_result(ies_pkg::record_t got, logic [9:0] got_total, logic got_last);
            ies_pkg::record_t want;
            logic [9:0]       want_total;
            bit               want_last;
            if (sorted_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tag %0h roll %0h",
                         $time, got.tag, got.roll);
                errors++;
                return;
            end
            want       = sorted_q.pop_front();
            want_last  = last_q.pop_front();
            want_total = 10'(initiative_sum(want));
            compare_field("roll", 16'(want.roll), 16'(got.roll));
            compare_field("modifier", 16'(want.modifier), 16'(got.modifier));
            compare_field("hit_points", want.hit_points, got.hit_points);
            compare_field("tag", 16'(want.tag), 16'(got.tag));
            compare_field("total", 16'(want_total), 16'(got_total));
            compare_field("end_of_run", 16'(want_last), 16'(got_last));
        endfunction

        function int unsigned pending();
            return sorted_q.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_roll;
    logic signed [7:0]  s_modifier;
    logic signed [15:0] s_hit_points;
    logic [7:0]         s_tag;
    logic               s_final_item;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [7:0]         m_out_roll;
    logic signed [7:0]  m_out_modifier;
    logic signed [15:0] m_out_hit_points;
    logic [7:0]         m_out_tag;
    logic signed [9:0]  m_total;
    logic               m_end_of_run;

    initiative_order_predictor order_model;
    bit          no_idle;
    bit          held_off     = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned stall_left   = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count  = 0;

    initiative_exchange_sorter_top #(
        .CAPACITY(STORE_DEPTH)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_roll          (s_roll),
        .s_modifier      (s_modifier),
        .s_hit_points    (s_hit_points),
        .s_tag           (s_tag),
        .s_final_item    (s_final_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_roll      (m_out_roll),
        .m_out_modifier  (m_out_modifier),
        .m_out_hit_points(m_out_hit_points),
        .m_out_tag       (m_out_tag),
        .m_total         (m_total),
        .m_end_of_run    (m_end_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function int unsigned draw_gap();
        int unsigned pick;
        if (no_idle) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // present one record and hold it until the transfer
    task automatic send_record(input logic [7:0] roll, input logic signed [7:0] modifier,
                               input logic signed [15:0] hit_points, input logic [7:0] tag,
                               input bit last);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_roll       <= roll;
        s_modifier   <= modifier;
        s_hit_points <= hit_points;
        s_tag        <= tag;
        s_final_item <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        order_model.take_record({roll, modifier, hit_points, tag}, last);
    endtask

    // narrow sets crowd the totals together so that ties are common
    task automatic send_set(input int unsigned count, input bit narrow);
        logic [7:0]         roll;
        logic signed [7:0]  modifier;
        logic signed [15:0] hit_points;
        logic [7:0]         tag;
        for (int k = 0; k < count; k++) begin
            if (narrow) begin
                roll     = 8'($urandom_range(8, 12));
                modifier = 8'($signed($urandom_range(0, 4)) - 2);
            end else begin
                roll     = 8'($urandom);
                modifier = 8'($urandom);
            end
            hit_points = 16'($urandom);
            tag        = 8'($urandom);
            send_record(roll, modifier, hit_points, tag, k == count - 1);
        end
    endtask

    initial begin
        int unsigned sent;
        int unsigned set_size;
        int          set_index;
        order_model  = new();
        no_idle      = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_roll       = '0;
        s_modifier   = '0;
        s_hit_points = '0;
        s_tag        = '0;
        s_final_item = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // single record at the top of every range
        send_record(8'd255, 8'sd127, 16'sd32767, 8'd255, 1'b1);
        // extremes, equal totals broken by roll, equal total and roll
        send_record(8'd0, -8'sd128, -16'sd32768, 8'd0, 1'b0);
        send_record(8'd0, 8'sd127, 16'sd1, 8'd1, 1'b0);
        send_record(8'd255, -8'sd128, -16'sd1, 8'd2, 1'b0);
        send_record(8'd127, 8'sd0, 16'sh5555, 8'd3, 1'b0);
        send_record(8'd50, 8'sd5, 16'sd100, 8'd4, 1'b0);
        send_record(8'd50, 8'sd5, 16'sd200, 8'd5, 1'b0);
        send_record(8'd55, 8'sd0, 16'sd300, 8'd6, 1'b0);
        send_record(8'd1, -8'sd1, 16'sd0, 8'd7, 1'b1);
        // identical keys, so that no record outranks another and none is swapped
        for (int k = 0; k < 4; k++) begin
            send_record(8'd20, -8'sd3, 16'(k * 1000), 8'(8 + k), k == 3);
        end
        sent = 13;

        // a full store with the final record stored, then a set that overflows
        for (set_index = 0; sent < TARGET_ITEMS; set_index++) begin
            if (set_index == 6) begin
                set_size = STORE_DEPTH;
            end else if (set_index == 14) begin
                set_size = STORE_DEPTH + 2;
            end else begin
                set_size = $urandom_range(1, 10);
            end
            no_idle = (set_index % 5 == 4);
            send_set(set_size, $urandom_range(0, 1));
            sent += set_size;
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;

        while (order_model.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (order_model.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // result side: random stalls plus one long hold-off while results are pending
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (!held_off && m_valid && results_seen >= 40) begin
            held_off  = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 99) < 20) begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 25)
                                                     : $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            order_model.match_result({m_out_roll, m_out_modifier, m_out_hit_points, m_out_tag},
                                     m_total, m_end_of_run);
            results_seen <= results_seen + 1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
